@@ src/ets_pkg.sv @@
// ----------------------------------------------------------------------------
// EDF tick scheduler package
// Shared constants, item codes, table entry layout and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ets_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int TICK_WIDTH_DEF = 16;

  localparam int FieldW   = 16;
  localparam int KindW    = 2;
  localparam int IdxInW   = 4;
  localparam int CountW   = 5;
  localparam int InDataW  = 56;
  localparam int OutDataW = 48;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_READ    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_SAT  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_READ,
    ST_OUT
  } st_e;

  // Static task parameters, written by a load item.
  typedef struct packed {
    logic [FieldW-1:0] period;
    logic [FieldW-1:0] exec;
    logic [FieldW-1:0] deadline;
  } task_t;

  // Per-entry result of the update unit.
  typedef struct packed {
    logic miss;
  } eval_flags_t;

endpackage

`default_nettype wire

@@ src/ets_entry_eval.sv @@
// ----------------------------------------------------------------------------
// EDF entry update unit
// Checks one task entry for a deadline miss and performs its job release.
// ----------------------------------------------------------------------------
`default_nettype none

module ets_entry_eval
  import ets_pkg::*;
#(
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  wire logic [TICK_WIDTH-1:0] time_i,
  input  wire task_t                 task_i,
  input  wire logic [FieldW-1:0]     rem_i,
  input  wire logic [TICK_WIDTH-1:0] adl_i,
  input  wire logic [TICK_WIDTH-1:0] rel_i,
  input  wire logic [FieldW-1:0]     cd_i,
  output logic      [FieldW-1:0]     rem_o,
  output logic      [TICK_WIDTH-1:0] adl_o,
  output logic      [TICK_WIDTH-1:0] rel_o,
  output logic      [FieldW-1:0]     cd_o,
  output eval_flags_t                flags_o
);

  localparam int SumW = ((TICK_WIDTH > FieldW) ? TICK_WIDTH : FieldW) + 1;
  localparam logic [TICK_WIDTH-1:0] TimeTop = {TICK_WIDTH{1'b1}};

  logic [SumW-1:0] dl_sum;
  logic            busy;
  logic            release_now;

  assign dl_sum      = SumW'(time_i) + SumW'(task_i.deadline);
  assign busy        = (rem_i != '0);
  assign release_now = (cd_i == '0);

  always_comb begin
    rem_o = rem_i;
    adl_o = adl_i;
    rel_o = rel_i;
    cd_o  = cd_i - FieldW'(1);
    if (release_now) begin
      // A new job replaces whatever was pending.
      rem_o = task_i.exec;
      adl_o = (dl_sum > SumW'(TimeTop)) ? TimeTop : dl_sum[TICK_WIDTH-1:0];
      rel_o = time_i;
      cd_o  = (task_i.period == '0) ? '0 : task_i.period - FieldW'(1);
    end
    flags_o.miss = busy && ((adl_i <= time_i) || release_now);
  end

endmodule

`default_nettype wire

@@ src/edf_tick_scheduler.sv @@
// ----------------------------------------------------------------------------
// EDF tick scheduler
// Earliest-deadline-first scheduler that advances time by one tick per tick item until time saturates.
// ----------------------------------------------------------------------------
// A tick walks the active task entries (the smaller of task_count and
// MAX_TASKS, called n) one per clock through a single entry update unit fed
// by the registered read of the task tables, then runs the chosen job in
// FINISH and sends its result beat from OUT; a tick at saturated time goes
// straight to OUT, as do load and restart items, while a worst-response
// read passes through READ. Only one item is in flight, and the input is
// ready again once the result beat has entered the output register.
`default_nettype none

module edf_tick_scheduler
  import ets_pkg::*;
#(
  parameter int MAX_TASKS  = MAX_TASKS_DEF,
  parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration: task_count.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CountW-1:0]   cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: task_index[3:0], period_value[19:4], exec_time[35:20],
  //        rel_deadline[51:36], zero fill[55:52]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // tuser: kind[1:0]
  input  wire logic [KindW-1:0]    s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: status[1:0], idle[2], run_task[6:3], job_done[7],
  //        response_time[23:8], wcrt_valid[24], wcrt_value[40:25],
  //        zero fill[47:41]
  output logic [OutDataW-1:0]      m_axis_tdata
);

  localparam int TW    = TICK_WIDTH;
  localparam int IdxW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int NW    = ($clog2(MAX_TASKS + 1) > CountW) ? $clog2(MAX_TASKS + 1) : CountW;
  localparam int ExtW  = IdxW + IdxInW;
  localparam int RespW = (TW > FieldW) ? TW : FieldW;
  localparam logic [TW-1:0] TimeTop = {TW{1'b1}};

  typedef struct packed {
    logic [FieldW-1:0] rem;
    logic [TW-1:0]     adl;
    logic [TW-1:0]     rel;
    logic [FieldW-1:0] cd;
    logic [FieldW-1:0] wcrt;
    logic              seen;
  } row_t;

  // Input unpacking.
  kind_e            in_kind;
  logic [ExtW-1:0]  in_ext;
  logic             in_range;
  logic [IdxW-1:0]  in_addr;
  task_t            in_task;
  logic             s_fire;

  assign in_kind         = kind_e'(s_axis_tuser);
  assign in_ext          = ExtW'(s_axis_tdata[3:0]);
  assign in_range        = in_ext < ExtW'(MAX_TASKS);
  assign in_addr         = in_ext[IdxW-1:0];
  assign in_task.period   = s_axis_tdata[19:4];
  assign in_task.exec     = s_axis_tdata[35:20];
  assign in_task.deadline = s_axis_tdata[51:36];

  // Control state.
  st_e                  state_q, state_d;
  logic [TW-1:0]        time_q, time_d;
  logic                 miss_q, miss_d;
  logic [CountW-1:0]    task_count_q;
  logic [MAX_TASKS-1:0] row_vld_q, row_vld_d;
  logic [NW-1:0]        scan_q, scan_d;
  logic [NW-1:0]        n_q, n_d;
  logic                 rd_pend_q, rd_pend_d;
  logic                 c_v_q, c_v_d;
  logic                 best_v_q, best_v_d;
  logic                 m_valid_q, m_valid_d;

  // Payload registers.
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  row_t                 c_row_q, c_row_d;
  logic [IdxW-1:0]      c_idx_q, c_idx_d;
  row_t                 best_row_q, best_row_d;
  logic [IdxW-1:0]      best_idx_q, best_idx_d;
  logic                 in_range_q, in_range_d;
  logic                 r_idle_q, r_idle_d;
  logic [3:0]           r_run_q, r_run_d;
  logic                 r_done_q, r_done_d;
  logic [FieldW-1:0]    r_resp_q, r_resp_d;
  logic                 r_wv_q, r_wv_d;
  logic [FieldW-1:0]    r_wval_q, r_wval_d;
  logic [OutDataW-1:0]  out_data_q, out_data_d;

  // Memories and their registered read ports.
  task_t                task_mem [MAX_TASKS];
  row_t                 run_mem  [MAX_TASKS];
  task_t                rd_task_q;
  row_t                 rd_row_q;
  logic                 vld_rd_q;
  logic [IdxW-1:0]      rd_addr;
  logic                 tk_we;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  row_t                 wr_row;

  row_t                 eff_row;
  row_t                 ev_row;
  eval_flags_t          ev_flags;
  logic [NW-1:0]        n_eff;
  logic                 c_better;
  logic [TW-1:0]        resp_diff;
  logic [RespW-1:0]     resp_ext;
  logic [FieldW-1:0]    resp_sat;
  logic                 fin_done;
  logic [FieldW-1:0]    fin_wcrt;
  logic [ExtW-1:0]      best_ext;
  status_e              status;

  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign n_eff   = (NW'(task_count_q) < NW'(MAX_TASKS)) ? NW'(task_count_q) : NW'(MAX_TASKS);
  assign rd_addr = (state_q == ST_IDLE) ? in_addr : scan_q[IdxW-1:0];
  assign tk_we   = s_fire && (in_kind == KIND_LOAD) && in_range;
  // A row never written since reset or restart reads as all zero.
  assign eff_row = vld_rd_q ? rd_row_q : '0;

  ets_entry_eval #(
    .TICK_WIDTH(TW)
  ) u_eval (
    .time_i (time_q),
    .task_i (rd_task_q),
    .rem_i  (eff_row.rem),
    .adl_i  (eff_row.adl),
    .rel_i  (eff_row.rel),
    .cd_i   (eff_row.cd),
    .rem_o  (ev_row.rem),
    .adl_o  (ev_row.adl),
    .rel_o  (ev_row.rel),
    .cd_o   (ev_row.cd),
    .flags_o(ev_flags)
  );
  assign ev_row.wcrt = eff_row.wcrt;
  assign ev_row.seen = eff_row.seen;

  // Equal deadlines go to the earlier release; full ties keep the earlier entry, which favors the lower index.
  assign c_better = (c_row_q.rem != '0) &&
                    (!best_v_q || (c_row_q.adl < best_row_q.adl) ||
                     ((c_row_q.adl == best_row_q.adl) && (c_row_q.rel < best_row_q.rel)));

  assign resp_diff = time_q - best_row_q.rel;
  assign resp_ext  = RespW'(resp_diff);
  assign resp_sat  = (resp_ext > RespW'(16'hFFFF)) ? 16'hFFFF : resp_ext[FieldW-1:0];
  assign fin_done  = (best_row_q.rem == FieldW'(1));
  assign fin_wcrt  = (fin_done && (!best_row_q.seen || (resp_sat >= best_row_q.wcrt))) ?
                     resp_sat : best_row_q.wcrt;
  assign best_ext  = ExtW'(best_idx_q);

  always_comb begin
    if (time_q == TimeTop) begin
      status = STATUS_SAT;
    end else if (miss_q) begin
      status = STATUS_MISS;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    state_d    = state_q;
    time_d     = time_q;
    miss_d     = miss_q;
    row_vld_d  = row_vld_q;
    scan_d     = scan_q;
    n_d        = n_q;
    rd_pend_d  = 1'b0;
    c_v_d      = 1'b0;
    best_v_d   = best_v_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    rd_idx_d   = rd_idx_q;
    c_row_d    = c_row_q;
    c_idx_d    = c_idx_q;
    best_row_d = best_row_q;
    best_idx_d = best_idx_q;
    in_range_d = in_range_q;
    r_idle_d   = r_idle_q;
    r_run_d    = r_run_q;
    r_done_d   = r_done_q;
    r_resp_d   = r_resp_q;
    r_wv_d     = r_wv_q;
    r_wval_d   = r_wval_q;
    out_data_d = out_data_q;
    wr_en      = 1'b0;
    wr_addr    = rd_idx_q;
    wr_row     = ev_row;

    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          r_idle_d = 1'b0;
          r_run_d  = '0;
          r_done_d = 1'b0;
          r_resp_d = '0;
          r_wv_d   = 1'b0;
          r_wval_d = '0;
          case (in_kind)
            KIND_LOAD: begin
              state_d = ST_OUT;
            end
            KIND_TICK: begin
              r_idle_d = 1'b1;
              if (time_q == TimeTop) begin
                state_d = ST_OUT;
              end else begin
                scan_d   = '0;
                n_d      = n_eff;
                best_v_d = 1'b0;
                state_d  = ST_SCAN;
              end
            end
            KIND_READ: begin
              in_range_d = in_range;
              state_d    = ST_READ;
            end
            default: begin
              time_d    = '0;
              miss_d    = 1'b0;
              row_vld_d = '0;
              state_d   = ST_OUT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue the read of the next entry.
        if (scan_q < n_q) begin
          scan_d    = scan_q + NW'(1);
          rd_pend_d = 1'b1;
          rd_idx_d  = scan_q[IdxW-1:0];
        end
        // Update the entry whose read data is here and write it back.
        if (rd_pend_q) begin
          c_v_d   = 1'b1;
          c_row_d = ev_row;
          c_idx_d = rd_idx_q;
          wr_en   = 1'b1;
          row_vld_d[rd_idx_q] = 1'b1;
          if (ev_flags.miss) begin
            miss_d = 1'b1;
          end
        end
        // Keep the earliest deadline seen so far.
        if (c_v_q && c_better) begin
          best_v_d   = 1'b1;
          best_row_d = c_row_q;
          best_idx_d = c_idx_q;
        end
        if ((scan_q == n_q) && !rd_pend_q && !c_v_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (best_v_q) begin
          r_idle_d    = 1'b0;
          r_run_d     = best_ext[3:0];
          r_done_d    = fin_done;
          r_resp_d    = fin_done ? resp_sat : '0;
          r_wv_d      = best_row_q.seen || fin_done;
          r_wval_d    = fin_wcrt;
          wr_en       = 1'b1;
          wr_addr     = best_idx_q;
          wr_row      = best_row_q;
          wr_row.rem  = best_row_q.rem - FieldW'(1);
          wr_row.wcrt = fin_wcrt;
          wr_row.seen = best_row_q.seen || fin_done;
        end
        time_d  = time_q + TW'(1);
        state_d = ST_OUT;
      end
      ST_READ: begin
        r_wv_d   = in_range_q && vld_rd_q && rd_row_q.seen;
        r_wval_d = (in_range_q && vld_rd_q) ? rd_row_q.wcrt : '0;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          out_data_d = {7'b0, r_wval_q, r_wv_q, r_resp_q, r_done_q, r_run_q, r_idle_q,
                        status};
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      time_q       <= '0;
      miss_q       <= 1'b0;
      task_count_q <= '0;
      row_vld_q    <= '0;
      scan_q       <= '0;
      n_q          <= '0;
      rd_pend_q    <= 1'b0;
      c_v_q        <= 1'b0;
      best_v_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      time_q    <= time_d;
      miss_q    <= miss_d;
      row_vld_q <= row_vld_d;
      scan_q    <= scan_d;
      n_q       <= n_d;
      rd_pend_q <= rd_pend_d;
      c_v_q     <= c_v_d;
      best_v_q  <= best_v_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i) begin
        task_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    c_row_q    <= c_row_d;
    c_idx_q    <= c_idx_d;
    best_row_q <= best_row_d;
    best_idx_q <= best_idx_d;
    in_range_q <= in_range_d;
    r_idle_q   <= r_idle_d;
    r_run_q    <= r_run_d;
    r_done_q   <= r_done_d;
    r_resp_q   <= r_resp_d;
    r_wv_q     <= r_wv_d;
    r_wval_q   <= r_wval_d;
    out_data_q <= out_data_d;
    vld_rd_q   <= row_vld_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (tk_we) begin
      task_mem[in_addr] <= in_task;
    end
    rd_task_q <= task_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      run_mem[wr_addr] <= wr_row;
    end
    rd_row_q <= run_mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// EDF tick scheduler testbench
// Drives load, tick, read and restart items with random gaps and stalls.
// A scoreboard class keeps its own copy of the task table and job state,
// predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ets_pkg::*;

  localparam int unsigned TimeTop = (1 << TICK_WIDTH_DEF) - 1;
  localparam int WatchLimit = 4000;
  localparam int PhaseItems = 165;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  idx;
    logic [15:0] period;
    logic [15:0] exec;
    logic [15:0] deadline;
  } sched_item_t;

  // Result fields, listed from the highest bit down to match the packing.
  typedef struct packed {
    logic [15:0] wcrt_value;
    logic        wcrt_valid;
    logic [15:0] response_time;
    logic        job_done;
    logic [3:0]  run_task;
    logic        idle;
    logic [1:0]  status;
  } sched_beat_t;

  class edf_scoreboard;
    logic [4:0]  task_count;
    int unsigned now;
    logic [15:0] period[16];
    logic [15:0] exec[16];
    logic [15:0] deadline[16];
    logic [15:0] remaining[16];
    logic [15:0] countdown[16];
    logic [15:0] worst[16];
    int unsigned abs_deadline[16];
    int unsigned released_at[16];
    bit          worst_seen[16];
    bit          miss;
    sched_beat_t expected_q[$];
    int unsigned errors;

    function new();
      task_count = '0;
      errors = 0;
      for (int i = 0; i < 16; i++) begin
        period[i] = '0;
        exec[i] = '0;
        deadline[i] = '0;
      end
      clear_run();
    endfunction

    function void clear_run();
      now = 0;
      miss = 1'b0;
      for (int i = 0; i < 16; i++) begin
        remaining[i] = '0;
        countdown[i] = '0;
        worst[i] = '0;
        abs_deadline[i] = 0;
        released_at[i] = 0;
        worst_seen[i] = 1'b0;
      end
    endfunction

    function void set_task_count(logic [4:0] value);
      task_count = value;
    endfunction

    function sched_beat_t tick_outcome();
      sched_beat_t r;
      int unsigned t;
      int unsigned d;
      int unsigned resp;
      int n;
      int best;
      r = '0;
      r.idle = 1'b1;
      t = now;
      n = (task_count > 16) ? 16 : int'(task_count);
      best = -1;
      if (t >= TimeTop) return r;
      // Misses are judged on the jobs left from before this tick's releases.
      for (int i = 0; i < n; i++)
        if (remaining[i] != 0 && abs_deadline[i] <= t) miss = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (countdown[i] == 0) begin
          d = t + deadline[i];
          if (remaining[i] != 0) miss = 1'b1;
          if (d > TimeTop) d = TimeTop;
          remaining[i] = exec[i];
          abs_deadline[i] = d;
          released_at[i] = t;
          countdown[i] = (period[i] != 0) ? period[i] - 16'd1 : 16'd0;
        end else begin
          countdown[i] = countdown[i] - 16'd1;
        end
      end
      for (int i = 0; i < n; i++) begin
        if (remaining[i] == 0) continue;
        if (best < 0 || abs_deadline[i] < abs_deadline[best] ||
            (abs_deadline[i] == abs_deadline[best] &&
             released_at[i] < released_at[best]))
          best = i;
      end
      if (best >= 0) begin
        r.idle = 1'b0;
        r.run_task = best[3:0];
        remaining[best] = remaining[best] - 16'd1;
        if (remaining[best] == 0) begin
          resp = t - released_at[best];
          if (resp > 65535) resp = 65535;
          r.job_done = 1'b1;
          r.response_time = resp[15:0];
          if (!worst_seen[best] || resp[15:0] >= worst[best]) begin
            worst[best] = resp[15:0];
            worst_seen[best] = 1'b1;
          end
        end
        r.wcrt_valid = worst_seen[best];
        r.wcrt_value = worst[best];
      end
      now = t + 1;
      return r;
    endfunction

    function void note_item(sched_item_t it);
      sched_beat_t r;
      r = '0;
      case (it.kind)
        KIND_LOAD: begin
          period[it.idx] = it.period;
          exec[it.idx] = it.exec;
          deadline[it.idx] = it.deadline;
        end
        KIND_TICK: r = tick_outcome();
        KIND_READ: begin
          r.wcrt_valid = worst_seen[it.idx];
          r.wcrt_value = worst[it.idx];
        end
        default: clear_run();
      endcase
      if (now >= TimeTop) r.status = STATUS_SAT;
      else if (miss) r.status = STATUS_MISS;
      else r.status = STATUS_OK;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void compare_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $error("%s: expected %0d, actual %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_beat(logic [OutDataW-1:0] data);
      sched_beat_t got;
      sched_beat_t exp;
      got = sched_beat_t'(data[$bits(sched_beat_t)-1:0]);
      if (expected_q.size() == 0) begin
        $error("result beat 0x%0h arrived with no item outstanding", data);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("status", exp.status, got.status);
      compare_field("idle", exp.idle, got.idle);
      compare_field("run_task", exp.run_task, got.run_task);
      compare_field("job_done", exp.job_done, got.job_done);
      compare_field("response_time", exp.response_time, got.response_time);
      compare_field("wcrt_valid", exp.wcrt_valid, got.wcrt_valid);
      compare_field("wcrt_value", exp.wcrt_value, got.wcrt_value);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CountW-1:0]   cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [KindW-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [OutDataW-1:0] m_axis_tdata;

  edf_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int quiet_cycles = 0;
  int stall_left = 0;

  edf_tick_scheduler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: check every accepted beat, then decide the next ready.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
    if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0) stall_left = pick_gap();
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("FAIL edf_tick_scheduler");
      $finish;
    end
  end

  task automatic push_item(input sched_item_t it);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, it.deadline, it.exec, it.period, it.idx};
    s_axis_tuser <= it.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  task automatic push_load(input int idx, input int p, input int e, input int d);
    sched_item_t it;
    it.kind = KIND_LOAD;
    it.idx = idx[3:0];
    it.period = p[15:0];
    it.exec = e[15:0];
    it.deadline = d[15:0];
    push_item(it);
  endtask

  task automatic push_simple(input kind_e kind, input int idx);
    sched_item_t it;
    it.kind = kind;
    it.idx = idx[3:0];
    it.period = 16'($urandom);
    it.exec = 16'($urandom);
    it.deadline = 16'($urandom);
    push_item(it);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_task_count(input logic [CountW-1:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_task_count(value);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic sched_item_t random_item();
    sched_item_t it;
    int unsigned r;
    it.idx = 4'($urandom_range(0, 15));
    it.period = 16'($urandom);
    it.exec = 16'($urandom);
    it.deadline = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 62) begin
      it.kind = KIND_TICK;
    end else if (r < 78) begin
      it.kind = KIND_LOAD;
      r = $urandom_range(0, 99);
      // Mostly short periods so that releases, preemption and completions
      // all happen within a few dozen ticks.
      if (r < 80) begin
        it.period = 16'($urandom_range(2, 24));
        it.exec = 16'($urandom_range(1, it.period / 3 + 1));
        it.deadline = 16'($urandom_range(1, it.period));
      end else if (r < 90) begin
        it.period = 16'($urandom_range(0, 3));
        it.exec = 16'($urandom_range(0, 2));
        it.deadline = 16'($urandom_range(0, 3));
      end else begin
        it.deadline = 16'($urandom_range(0, it.period));
      end
    end else if (r < 98) begin
      it.kind = KIND_READ;
    end else begin
      it.kind = KIND_RESTART;
    end
    return it;
  endfunction

  initial begin
    logic [CountW-1:0] phase_count[8];
    phase_count = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd5, 5'd17, 5'd3, 5'd8};
    phase_count[7] = 5'($urandom_range(0, 31));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty table, then a table with every corner entry.
    write_task_count(5'd0);
    push_simple(KIND_TICK, 0);
    push_simple(KIND_READ, 5);
    push_load(0, 4, 1, 4);
    push_load(1, 6, 2, 5);
    push_load(2, 0, 1, 1);              // releases on every tick
    push_load(3, 5, 0, 5);              // release makes no pending job
    push_load(4, 65535, 65535, 65535);
    push_load(5, 1, 1, 1);
    push_load(6, 10, 3, 10);
    push_load(7, 10, 3, 10);            // same deadline as entry 6: index decides
    for (int i = 8; i < 16; i++) push_load(i, 8 + 4 * (i - 8), 1 + i % 3, 8 + 4 * (i - 8));
    write_task_count(5'd31);
    repeat (5) push_simple(KIND_TICK, 0);
    push_simple(KIND_READ, 4);
    push_simple(KIND_RESTART, 0);

    for (int ph = 0; ph < 8; ph++) begin
      gaps_on = (ph % 3 != 2);
      write_task_count(phase_count[ph]);
      // Every other phase starts again from time zero.
      if (ph % 2 == 0) push_simple(KIND_RESTART, 0);
      repeat (PhaseItems) push_item(random_item());
    end

    drain_results();
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS edf_tick_scheduler");
    end else begin
      $display("FAIL edf_tick_scheduler");
    end
    $finish;
  end

endmodule

@@ edf_tick_scheduler.f @@
src/ets_pkg.sv
src/ets_entry_eval.sv
src/edf_tick_scheduler.sv
tb/tb.sv
